// ===== design/c2e_pkg.sv =====
package c2e_pkg;

    // Epoch year and the offset of the year field.
    localparam int BASE_YEAR_DEFAULT = 1970;
    localparam int YEAR_OFFSET       = 1900;

    // Field widths.
    localparam int YEAR_W    = 8;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int SECOND_W  = 6;
    localparam int ZONE_W    = 11;
    localparam int EPOCH_W   = 34;
    localparam int FULLYEAR_W = 12;
    localparam int FACTOR_W  = 6;

    // Stream word widths, padded to whole bytes.
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    // Range limits and calendar constants.
    localparam int LAST_MONTH       = 11;
    localparam int LAST_DAY         = 31;
    localparam int ROLLOVER_HOUR    = 24;
    localparam int LAST_MINUTE      = 59;
    localparam int LAST_SECOND      = 59;
    localparam int MARCH_INDEX      = 2;
    localparam int DAYS_COMMON_YEAR = 365;
    localparam int DAYS_LEAP_YEAR   = 366;
    localparam int HOURS_PER_DAY    = 24;
    localparam int MINUTES_PER_HOUR = 60;
    localparam int SECONDS_PER_MIN  = 60;

    // Length of a month in a common year.
    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] len;
        unique case (month)
            4'd1:                   len = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== design/calendar_to_epoch_seconds_core.sv =====
// An accepted input word runs through the year loop (none for years before BASE_YEAR),
// the month loop, the day, hour, minute, zone and second steps and ST_DONE; a range error goes straight to ST_DONE.
// One word at a time: s_tready is high only while the sequencer is idle, and the year loop
// runs through the shared multiply-add unit.
// Reset (rst_n low, asynchronous) empties the output register, returns the sequencer
// to idle and clears the zone offset to 0.
module calendar_to_epoch_seconds_core #(
    parameter int BASE_YEAR = c2e_pkg::BASE_YEAR_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // Zone offset register, minutes west of UTC, two's complement.
    input  logic                              cfg_we,
    input  logic [c2e_pkg::ZONE_W-1:0]        cfg_wdata,

    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0 up: year_since_1900[7:0], month_index[11:8], day_of_month[16:12],
    // hour_of_day[21:17], minute_of_hour[27:22], second_of_minute[33:28],
    // daylight_active[34], zero padding[39:35].
    input  logic [c2e_pkg::IN_DATA_W-1:0]     s_tdata,

    // Output stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // Fields from bit 0 up: epoch_seconds[33:0] (signed), zero padding[39:34].
    output logic [c2e_pkg::OUT_DATA_W-1:0]    m_tdata,
    // Fields from bit 0 up: range_error[0].
    output logic                              m_tuser
);

    localparam int EW = c2e_pkg::EPOCH_W;
    localparam int YW = c2e_pkg::FULLYEAR_W;
    localparam int FW = c2e_pkg::FACTOR_W;

    // The sequencer walks through the steps below. Every arithmetic step goes through
    // one multiply-add unit: acc = acc * factor + addend.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_YEAR,
        ST_MONTH,
        ST_DAY,
        ST_HOUR,
        ST_MIN,
        ST_ZONE,
        ST_SEC,
        ST_DONE
    } state_t;

    state_t                           state_reg, state_next;

    // Captured input fields.
    logic [YW-1:0]                    year_reg, year_next;
    logic [c2e_pkg::MONTH_W-1:0]      month_reg, month_next;
    logic [c2e_pkg::DAY_W-1:0]        day_reg, day_next;
    logic [c2e_pkg::HOUR_W-1:0]       hour_reg, hour_next;
    logic [c2e_pkg::MINUTE_W-1:0]     minute_reg, minute_next;
    logic [c2e_pkg::SECOND_W-1:0]     second_reg, second_next;
    logic                             dst_reg, dst_next;
    logic                             err_reg, err_next;

    // Loop counters and accumulator.
    logic [YW-1:0]                    ycnt_reg, ycnt_next;
    logic [c2e_pkg::MONTH_W-1:0]      mcnt_reg, mcnt_next;
    logic signed [EW-1:0]             acc_reg, acc_next;

    logic signed [c2e_pkg::ZONE_W-1:0] zone_reg, zone_next;

    logic                             m_tvalid_reg, m_tvalid_next;
    logic [EW-1:0]                    out_epoch_reg, out_epoch_next;
    logic                             out_err_reg, out_err_next;

    // Shared unit operands.
    logic [FW-1:0]                    factor;
    logic signed [EW-1:0]             addend;
    logic signed [EW-1:0]             alu_result;

    // Unpacked input fields.
    logic [c2e_pkg::YEAR_W-1:0]       in_year;
    logic [c2e_pkg::MONTH_W-1:0]      in_month;
    logic [c2e_pkg::DAY_W-1:0]        in_day;
    logic [c2e_pkg::HOUR_W-1:0]       in_hour;
    logic [c2e_pkg::MINUTE_W-1:0]     in_minute;
    logic [c2e_pkg::SECOND_W-1:0]     in_second;
    logic                             in_dst;
    logic                             in_bad;

    logic                             year_leap;
    logic                             hour_rolls;
    logic                             in_accept;

    assign in_year   = s_tdata[7:0];
    assign in_month  = s_tdata[11:8];
    assign in_day    = s_tdata[16:12];
    assign in_hour   = s_tdata[21:17];
    assign in_minute = s_tdata[27:22];
    assign in_second = s_tdata[33:28];
    assign in_dst    = s_tdata[34];

    // Any field out of its range makes the whole word an error.
    assign in_bad = (in_month > c2e_pkg::MONTH_W'(c2e_pkg::LAST_MONTH))
                 || (in_day == '0)
                 || (in_day > c2e_pkg::DAY_W'(c2e_pkg::LAST_DAY))
                 || (in_hour > c2e_pkg::HOUR_W'(c2e_pkg::ROLLOVER_HOUR))
                 || (in_minute > c2e_pkg::MINUTE_W'(c2e_pkg::LAST_MINUTE))
                 || (in_second > c2e_pkg::SECOND_W'(c2e_pkg::LAST_SECOND));

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // Leap years follow the plain divisible-by-four rule.
    assign year_leap  = (year_reg[1:0] == 2'b00);
    assign hour_rolls = (hour_reg == c2e_pkg::HOUR_W'(c2e_pkg::ROLLOVER_HOUR));

    // The shared multiply-add unit. The factor is at most 60, so one narrow
    // multiplier serves every step.
    assign alu_result = acc_reg * $signed({1'b0, factor}) + addend;

    // Operand selection for the current step.
    always_comb
    begin
        factor = FW'(1);
        addend = '0;
        unique case (state_reg)
            ST_YEAR:
            begin
                addend = ycnt_reg[1:0] == 2'b00 ? EW'(c2e_pkg::DAYS_LEAP_YEAR)
                                                : EW'(c2e_pkg::DAYS_COMMON_YEAR);
            end
            ST_MONTH:
            begin
                addend = EW'(c2e_pkg::month_length(mcnt_reg));
            end
            ST_DAY:
            begin
                // Day counts from one; hour 24 adds the next day; a leap year
                // adds its extra day from March on.
                addend = EW'(day_reg) - EW'(1) + EW'(hour_rolls)
                       + EW'(year_leap && (month_reg >= c2e_pkg::MONTH_W'(c2e_pkg::MARCH_INDEX)));
            end
            ST_HOUR:
            begin
                factor = FW'(c2e_pkg::HOURS_PER_DAY);
                addend = hour_rolls ? '0 : EW'(hour_reg);
            end
            ST_MIN:
            begin
                factor = FW'(c2e_pkg::MINUTES_PER_HOUR);
                addend = EW'(minute_reg);
            end
            ST_ZONE:
            begin
                // The total is in minutes here, so the zone adds directly and
                // daylight saving takes off one hour of minutes.
                addend = EW'(zone_reg)
                       - (dst_reg ? EW'(c2e_pkg::MINUTES_PER_HOUR) : '0);
            end
            ST_SEC:
            begin
                factor = FW'(c2e_pkg::SECONDS_PER_MIN);
                addend = EW'(second_reg);
            end
            default:
            begin
                factor = FW'(1);
                addend = '0;
            end
        endcase
    end

    // Sequencer next state.
    always_comb
    begin
        state_next     = state_reg;
        year_next      = year_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        hour_next      = hour_reg;
        minute_next    = minute_reg;
        second_next    = second_reg;
        dst_next       = dst_reg;
        err_next       = err_reg;
        ycnt_next      = ycnt_reg;
        mcnt_next      = mcnt_reg;
        acc_next       = acc_reg;
        zone_next      = cfg_we ? $signed(cfg_wdata) : zone_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        out_epoch_next = out_epoch_reg;
        out_err_next   = out_err_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    year_next   = YW'(in_year) + YW'(c2e_pkg::YEAR_OFFSET);
                    month_next  = in_month;
                    day_next    = in_day;
                    hour_next   = in_hour;
                    minute_next = in_minute;
                    second_next = in_second;
                    dst_next    = in_dst;
                    err_next    = in_bad;
                    ycnt_next   = YW'(BASE_YEAR);
                    mcnt_next   = '0;
                    if (in_bad)
                    begin
                        acc_next   = '1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        acc_next   = '0;
                        state_next = ST_YEAR;
                    end
                end
            end
            ST_YEAR:
            begin
                if (ycnt_reg < year_reg)
                begin
                    acc_next  = alu_result;
                    ycnt_next = ycnt_reg + YW'(1);
                end
                else
                begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH:
            begin
                if (mcnt_reg < month_reg)
                begin
                    acc_next  = alu_result;
                    mcnt_next = mcnt_reg + c2e_pkg::MONTH_W'(1);
                end
                else
                begin
                    state_next = ST_DAY;
                end
            end
            ST_DAY:
            begin
                acc_next   = alu_result;
                state_next = ST_HOUR;
            end
            ST_HOUR:
            begin
                acc_next   = alu_result;
                state_next = ST_MIN;
            end
            ST_MIN:
            begin
                acc_next   = alu_result;
                state_next = ST_ZONE;
            end
            ST_ZONE:
            begin
                acc_next   = alu_result;
                state_next = ST_SEC;
            end
            ST_SEC:
            begin
                acc_next   = alu_result;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Hand the result over once the output register is free.
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next  = 1'b1;
                    out_epoch_next = acc_reg;
                    out_err_next   = err_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            zone_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            zone_reg     <= zone_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        year_reg      <= year_next;
        month_reg     <= month_next;
        day_reg       <= day_next;
        hour_reg      <= hour_next;
        minute_reg    <= minute_next;
        second_reg    <= second_next;
        dst_reg       <= dst_next;
        err_reg       <= err_next;
        ycnt_reg      <= ycnt_next;
        mcnt_reg      <= mcnt_next;
        acc_reg       <= acc_next;
        out_epoch_reg <= out_epoch_next;
        out_err_reg   <= out_err_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(c2e_pkg::OUT_DATA_W-EW){1'b0}}, out_epoch_reg};
    assign m_tuser  = out_err_reg;

endmodule
